// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// Package: word types, command and status codes, controller-datapath interface types.
package spq_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOPLACE = 2'd3;

  localparam logic [2:0] RA_ZERO   = 3'd0;
  localparam logic [2:0] RA_TAIL   = 3'd1;
  localparam logic [2:0] RA_IDX    = 3'd2;
  localparam logic [2:0] RA_IDX_M1 = 3'd3;
  localparam logic [2:0] RA_IDX_P1 = 3'd4;

  localparam logic WD_ITEM  = 1'b0;
  localparam logic WD_RDATA = 1'b1;

  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_ZERO  = 3'd1;
  localparam logic [2:0] IDX_ONE   = 3'd2;
  localparam logic [2:0] IDX_COUNT = 3'd3;
  localparam logic [2:0] IDX_INC   = 3'd4;
  localparam logic [2:0] IDX_DEC   = 3'd5;

  localparam logic [1:0] POS_HOLD  = 2'd0;
  localparam logic [1:0] POS_ZERO  = 2'd1;
  localparam logic [1:0] POS_COUNT = 2'd2;
  localparam logic [1:0] POS_IDX   = 2'd3;

  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  localparam logic [1:0] HEAD_HOLD  = 2'd0;
  localparam logic [1:0] HEAD_CLEAR = 2'd1;
  localparam logic [1:0] HEAD_LOAD  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic       cap_item;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic [2:0] idx_op;
    logic [1:0] pos_op;
    logic [1:0] cnt_op;
    logic       prev_ld;
    logic [1:0] head_op;
    logic       out_ld;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full;
    logic       idx_eq_pos;
    logic       idx_is_last;
    logic       pri_gt_rd;
    logic       pri_le_rd;
    logic       prev_ge_pri;
    logic       rd_lt_pri;
  } dp_sts_t;

endpackage

// ===== sv/spq_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: entry memory, fill count, index registers, compares and result register.
module spq_datapath #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spq_pkg::in_t     in_data,
  input  spq_pkg::dp_cmd_t cmd,
  output spq_pkg::dp_sts_t sts,
  output spq_pkg::out_t    out_data
);
  import spq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PB = PRIORITY_BITS;
  localparam int DW = 32 + PB;

  logic [DW-1:0]        mem_r [QUEUE_DEPTH];
  logic [DW-1:0]        rdata_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [1:0]           item_cmd_r;
  logic [31:0]          item_val_r;
  logic signed [PB-1:0] item_pri_r;
  logic signed [PB-1:0] prev_r;
  logic [31:0]          head_val_r;
  logic [PB-1:0]        head_pri_r;
  out_t                 out_data_r;

  logic [PB-1:0]        in_pri;
  logic [15:0]          head_pri16;
  logic [CW-1:0]        count_m1;
  logic [AW-1:0]        count_a;
  logic [AW-1:0]        tail_a;
  logic [AW-1:0]        raddr;
  logic [DW-1:0]        wdata;
  logic [31:0]          rd_val;
  logic signed [PB-1:0] rd_pri;

  if (PB <= 16) begin : g_in_narrow
    assign in_pri = in_data.item_priority[PB-1:0];
  end else begin : g_in_wide
    assign in_pri = {{(PB-16){1'b0}}, in_data.item_priority};
  end

  if (PB >= 16) begin : g_out_narrow
    assign head_pri16 = head_pri_r[15:0];
  end else begin : g_out_wide
    assign head_pri16 = {{(16-PB){1'b0}}, head_pri_r};
  end

  assign count_m1 = count_r - 1'b1;
  assign count_a  = count_r[AW-1:0];
  assign tail_a   = count_m1[AW-1:0];
  assign rd_val   = rdata_r[DW-1:PB];
  assign rd_pri   = rdata_r[PB-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RA_ZERO:   raddr = '0;
      RA_TAIL:   raddr = tail_a;
      RA_IDX:    raddr = idx_r;
      RA_IDX_M1: raddr = idx_r - 1'b1;
      RA_IDX_P1: raddr = idx_r + 1'b1;
      default:   raddr = '0;
    endcase
  end

  assign wdata = (cmd.wr_sel == WD_RDATA) ? rdata_r : {item_val_r, item_pri_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[idx_r] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + 1'b1;
      CNT_DEC: count_nxt = count_m1;
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO:  idx_nxt = '0;
      IDX_ONE:   idx_nxt = AW'(1);
      IDX_COUNT: idx_nxt = count_a;
      IDX_INC:   idx_nxt = idx_r + 1'b1;
      IDX_DEC:   idx_nxt = idx_r - 1'b1;
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.pos_op)
      POS_ZERO:  pos_nxt = '0;
      POS_COUNT: pos_nxt = count_a;
      POS_IDX:   pos_nxt = idx_r;
      default:   pos_nxt = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (cmd.cap_item) begin
      item_cmd_r <= in_data.command;
      item_val_r <= in_data.item_value;
      item_pri_r <= in_pri;
    end
    if (cmd.prev_ld) begin
      prev_r <= rd_pri;
    end
    case (cmd.head_op)
      HEAD_CLEAR: begin
        head_val_r <= '0;
        head_pri_r <= '0;
      end
      HEAD_LOAD: begin
        head_val_r <= rd_val;
        head_pri_r <= rd_pri;
      end
      default: begin
        head_val_r <= head_val_r;
        head_pri_r <= head_pri_r;
      end
    endcase
    if (cmd.out_ld) begin
      out_data_r.out_value    <= head_val_r;
      out_data_r.out_priority <= head_pri16;
      out_data_r.status       <= cmd.status;
    end
  end

  assign sts.cmd         = item_cmd_r;
  assign sts.empty       = (count_r == '0);
  assign sts.full        = (count_r == CW'(QUEUE_DEPTH));
  assign sts.idx_eq_pos  = (idx_r == pos_r);
  assign sts.idx_is_last = (idx_r == tail_a);
  assign sts.pri_gt_rd   = (item_pri_r > rd_pri);
  assign sts.pri_le_rd   = (item_pri_r <= rd_pri);
  assign sts.prev_ge_pri = (prev_r >= item_pri_r);
  assign sts.rd_lt_pri   = (rd_pri < item_pri_r);

  assign out_data = out_data_r;

endmodule

// ===== sv/spq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences head/tail checks, position scan, entry shifts and result delivery.
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  spq_pkg::dp_sts_t sts,
  output spq_pkg::dp_cmd_t cmd
);
  import spq_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_CHK_HEAD  = 4'd2;
  localparam logic [3:0] S_CHK_TAIL  = 4'd3;
  localparam logic [3:0] S_SCAN_RD   = 4'd4;
  localparam logic [3:0] S_SCAN_CHK  = 4'd5;
  localparam logic [3:0] S_SHIFT_CHK = 4'd6;
  localparam logic [3:0] S_SH_WR     = 4'd7;
  localparam logic [3:0] S_CAP_HEAD  = 4'd8;
  localparam logic [3:0] S_RM_CHK    = 4'd9;
  localparam logic [3:0] S_RM_WR     = 4'd10;
  localparam logic [3:0] S_FINISH    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.head_op = HEAD_CLEAR;
        st_nxt      = ST_DONE;
        if (sts.cmd inside {CMD_APPEND, CMD_INSERT}) begin
          if (sts.full) begin
            st_nxt    = ST_FULL;
            state_nxt = S_FINISH;
          end else if (sts.cmd == CMD_APPEND || sts.empty) begin
            cmd.idx_op = IDX_COUNT;
            cmd.pos_op = POS_COUNT;
            state_nxt  = S_SHIFT_CHK;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_ZERO;
            state_nxt  = S_CHK_HEAD;
          end
        end else if (sts.cmd == CMD_REMOVE) begin
          if (sts.empty) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_FINISH;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_ZERO;
            state_nxt  = S_CAP_HEAD;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CHK_HEAD: begin
        if (sts.pri_gt_rd) begin
          cmd.idx_op = IDX_COUNT;
          cmd.pos_op = POS_ZERO;
          state_nxt  = S_SHIFT_CHK;
        end else begin
          cmd.prev_ld = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_TAIL;
          state_nxt   = S_CHK_TAIL;
        end
      end
      S_CHK_TAIL: begin
        if (sts.pri_le_rd) begin
          cmd.idx_op = IDX_COUNT;
          cmd.pos_op = POS_COUNT;
          state_nxt  = S_SHIFT_CHK;
        end else begin
          cmd.idx_op = IDX_ONE;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_IDX;
        state_nxt  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.prev_ge_pri && sts.rd_lt_pri) begin
          cmd.pos_op = POS_IDX;
          cmd.idx_op = IDX_COUNT;
          state_nxt  = S_SHIFT_CHK;
        end else if (sts.idx_is_last) begin
          st_nxt    = ST_NOPLACE;
          state_nxt = S_FINISH;
        end else begin
          cmd.prev_ld = 1'b1;
          cmd.idx_op  = IDX_INC;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SHIFT_CHK: begin
        if (sts.idx_eq_pos) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WD_ITEM;
          cmd.cnt_op = CNT_INC;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX_M1;
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_RDATA;
        cmd.idx_op = IDX_DEC;
        state_nxt  = S_SHIFT_CHK;
      end
      S_CAP_HEAD: begin
        cmd.head_op = HEAD_LOAD;
        cmd.idx_op  = IDX_ZERO;
        state_nxt   = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (sts.idx_is_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX_P1;
          state_nxt  = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WD_RDATA;
        cmd.idx_op = IDX_INC;
        state_nxt  = S_RM_CHK;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          cmd.status    = st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Top level: stable priority queue with sorted insert, controller plus datapath.
// Bounded queue of (value, priority) entries held in a single-port-read, single-port-write
// memory of QUEUE_DEPTH words. One command word is taken at a time and gives exactly one
// result word. An append, or an insert into an empty queue, writes the item at the tail. A
// full-queue insert, an empty remove or the unused command goes straight to the result. A
// priority insert checks the head, then the tail when the entry does not go to the head,
// and scans the middle entries when it goes to neither end; it then moves each entry
// behind its place one step toward the tail. A remove captures the head and moves each
// remaining entry one step toward the head. Each entry moved takes one memory read and one
// memory write. A new command is taken while the previous result is still waiting on the
// output register, but its own result is held until that one is taken.
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::out_t out_data
);
  import spq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.cnt_op == CNT_INC) |-> !dp_sts.full)
    else $error("fill count advanced on a full queue");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.cnt_op == CNT_DEC) |-> !dp_sts.empty)
    else $error("fill count dropped on an empty queue");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in work");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_ld |-> (!out_valid || out_ready))
    else $error("result register overwritten before delivery");
`endif

endmodule

// ===== test/tb_stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Testbench: directed and random command words checked against a mirror of the priority queue.
module tb_stable_priority_queue_top;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 1350;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FIRST  = 600;
  localparam int QUIET_LAST   = 850;

  typedef struct packed {
    logic signed [31:0] val;
    logic signed [15:0] prio;
  } entry_t;

  class queue_mirror;
    entry_t entries[$];
    out_t   pending_words[$];
    int     mismatches;

    function out_t predict_word(in_t w);
      out_t               r;
      entry_t             e;
      logic signed [15:0] p;
      int                 pos;
      r = '0;
      r.status = ST_DONE;
      e.val = w.item_value;
      e.prio = w.item_priority;
      p = w.item_priority;
      case (w.command)
        CMD_APPEND, CMD_INSERT: begin
          if (entries.size() >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else if (w.command == CMD_APPEND || entries.size() == 0) begin
            entries.push_back(e);
          end else if (p > entries[0].prio) begin
            entries.push_front(e);
          end else if (p <= entries[entries.size() - 1].prio) begin
            entries.push_back(e);
          end else begin
            pos = -1;
            for (int i = 0; i + 1 < entries.size(); i++) begin
              if (pos < 0 && entries[i].prio >= p && entries[i + 1].prio < p) pos = i + 1;
            end
            if (pos < 0) r.status = ST_NOPLACE;
            else entries.insert(pos, e);
          end
        end
        CMD_REMOVE: begin
          if (entries.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            e = entries.pop_front();
            r.out_value = e.val;
            r.out_priority = e.prio;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_command(in_t w);
      pending_words.push_back(predict_word(w));
    endfunction

    function void report(string what, out_t want, out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected value %0d prio %0d status %0d, got value %0d prio %0d status %0d",
                 what, want.out_value, want.out_priority, want.status,
                 got.out_value, got.out_priority, got.status);
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (pending_words.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = pending_words.pop_front();
      if (got.out_value !== want.out_value || got.out_priority !== want.out_priority ||
          got.status !== want.status)
        report("wrong word", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  queue_mirror board = new();
  int accepted_words = 0;
  int cycle_count = 0;

  stable_priority_queue_top #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(16)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stable_priority_queue_top: mismatch");
      $finish;
    end
  end

  function automatic bit quiet_stretch();
    return accepted_words >= QUIET_FIRST && accepted_words < QUIET_LAST;
  endfunction

  function automatic in_t make_word(logic [1:0] cmd, logic [31:0] val, logic [15:0] pri);
    in_t w;
    w.command = cmd;
    w.item_value = val;
    w.item_priority = pri;
    return w;
  endfunction

  function automatic in_t random_word(int mode);
    int         pick;
    int         pr;
    logic [1:0] cmd;
    logic [15:0] pri;
    pick = $urandom_range(99);
    case (mode)
      0: cmd = pick < 3 ? CMD_NONE : pick < 25 ? CMD_APPEND : pick < 75 ? CMD_INSERT : CMD_REMOVE;
      1: cmd = pick < 3 ? CMD_NONE : pick < 13 ? CMD_APPEND : pick < 33 ? CMD_INSERT : CMD_REMOVE;
      default:
        cmd = pick < 3 ? CMD_NONE : pick < 20 ? CMD_APPEND : pick < 55 ? CMD_INSERT : CMD_REMOVE;
    endcase
    pr = $urandom_range(99);
    if (pr < 55) pri = 16'($signed($urandom_range(8)) - 4);
    else if (pr < 80) pri = 16'($signed($urandom_range(200)) - 100);
    else pri = 16'($urandom);
    return make_word(cmd, $urandom, pri);
  endfunction

  task automatic offer_word(in_t w);
    @(negedge clk);
    while (!quiet_stretch() && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(w);
    accepted_words++;
  endtask

  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && accepted_words >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_stretch() || $urandom_range(99) >= 8;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && out_ready) board.check_word(out_data);
  end

  initial begin
    int   counted;
    int   mode;
    in_t  w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    offer_word(make_word(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF));
    offer_word(make_word(CMD_NONE, $urandom, 16'($urandom)));
    offer_word(make_word(CMD_INSERT, 32'h7FFF_FFFF, 16'sd0));
    offer_word(make_word(CMD_INSERT, 32'h0000_0001, 16'sd32767));
    offer_word(make_word(CMD_INSERT, 32'h8000_0000, 16'h8000));
    offer_word(make_word(CMD_INSERT, 32'h0000_0002, 16'h8000));
    offer_word(make_word(CMD_INSERT, 32'h0000_0003, 16'sd50));
    offer_word(make_word(CMD_INSERT, 32'h0000_0004, 16'sd50));
    offer_word(make_word(CMD_APPEND, 32'h8000_0000, 16'sd32767));
    repeat (9) offer_word(make_word(CMD_APPEND, $urandom, 16'($urandom)));
    offer_word(make_word(CMD_APPEND, 32'h1234_5678, 16'sd7));
    offer_word(make_word(CMD_INSERT, 32'h1234_5679, 16'sd7));
    offer_word(make_word(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF));
    offer_word(make_word(CMD_REMOVE, 32'h0000_0000, 16'h0000));

    counted = 0;
    mode = 0;
    while (counted < RANDOM_WORDS) begin
      if (counted % 40 == 0) mode = $urandom_range(2);
      w = random_word(mode);
      offer_word(w);
      if (w.command != CMD_NONE) counted++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("stable_priority_queue_top: match");
    end else begin
      $display("stable_priority_queue_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/spq_pkg.sv
sv/spq_datapath.sv
sv/spq_ctrl.sv
sv/stable_priority_queue_top.sv
test/tb_stable_priority_queue_top.sv
